### rtl/core/hcpr_pkg.sv
// ----------------------------------------------------------------------------
// hcpr_pkg
// Shared types and constants of the hash cluster probe and replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package hcpr_pkg;

    localparam int CLUSTERS    = 1024;
    localparam int WAYS        = 3;
    localparam int CLUSTER_W   = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int ENTRY_W     = 32;
    localparam int ROW_W       = WAYS * ENTRY_W;
    localparam int TAG_W       = 16;
    localparam int GEN_W       = 6;
    localparam int WAY_W       = 2;
    localparam int RV_W        = 11;

    // Age is (259 + gen8 - genbyte) & 0xFC; only the low byte of 259 matters.
    localparam logic [7:0] AGE_BIAS = 8'd3;
    localparam logic [7:0] GEN_MASK = 8'hFC;
    localparam logic [7:0] GEN_STEP = 8'd4;

    localparam logic FUNC_PROBE = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic              func;
        logic [63:0]       key;
        logic [WAY_W-1:0]  way;
        logic signed [7:0] depth;
        logic [1:0]        bound;
    } item_t;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  slot;
        logic signed [7:0] entry_depth;
        logic [1:0]        entry_bound;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load;
        logic                 exec;
        logic                 clear;
        logic [CLUSTER_W-1:0] clr_addr;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/core/hcpr_ram.sv
// ----------------------------------------------------------------------------
// hcpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/hcpr_ctrl.sv
// ----------------------------------------------------------------------------
// hcpr_ctrl
// Controller: clearing sweep after reset, then accept and execute items.
// ----------------------------------------------------------------------------
`default_nettype none

module hcpr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output hcpr_pkg::cmd_t     cmd
);
    import hcpr_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CLUSTER_W-1:0] clr_cnt_reg, clr_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd.load     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.clear    = 1'b0;
        cmd.clr_addr = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (clr_cnt_reg == CLUSTER_W'(CLUSTERS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/hcpr_dp.sv
// ----------------------------------------------------------------------------
// hcpr_dp
// Datapath: cluster RAM, way scan, victim selection, write-back and result.
// ----------------------------------------------------------------------------
`default_nettype none

module hcpr_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hcpr_pkg::cmd_t                cmd,
    input  wire hcpr_pkg::item_t               item,
    input  wire logic                          cfg_we,
    input  wire logic [hcpr_pkg::GEN_W-1:0]    cfg_wdata,
    output logic                               done,
    output hcpr_pkg::result_t                  result
);
    import hcpr_pkg::*;

    item_t                item_reg;
    logic [GEN_W-1:0]     gen_reg;
    result_t              result_reg, result_next;
    logic                 done_reg;

    logic [ROW_W-1:0]     row_rd;
    logic [ROW_W-1:0]     row_new;
    logic                 wr_en;
    logic                 ram_we;
    logic [CLUSTER_W-1:0] ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic [CLUSTER_W-1:0] in_idx;
    logic [CLUSTER_W-1:0] cur_idx;

    logic [TAG_W-1:0]        etag  [WAYS];
    logic [7:0]              egb   [WAYS];
    logic signed [7:0]       edep  [WAYS];
    logic signed [RV_W-1:0]  rv    [WAYS];
    logic [7:0]              gen8;
    logic [TAG_W-1:0]        tag;

    assign in_idx  = item.key[CLUSTER_W-1:0] & CLUSTER_W'(CLUSTERS - 1);
    assign cur_idx = item_reg.key[CLUSTER_W-1:0] & CLUSTER_W'(CLUSTERS - 1);
    assign gen8    = {gen_reg, 2'b00};
    assign tag     = item_reg.key[63:64-TAG_W];

    hcpr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CLUSTERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (in_idx),
        .rdata (row_rd)
    );

    assign ram_we    = cmd.clear | (cmd.exec & wr_en);
    assign ram_waddr = cmd.clear ? cmd.clr_addr : cur_idx;
    assign ram_wdata = cmd.clear ? '0 : row_new;

    // Field split and replacement value of every way.
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            etag[i] = row_rd[i*ENTRY_W+16 +: TAG_W];
            egb[i]  = row_rd[i*ENTRY_W+8 +: 8];
            edep[i] = row_rd[i*ENTRY_W +: 8];
            rv[i]   = RV_W'(edep[i])
                      - $signed({2'b00, ((AGE_BIAS + gen8 - egb[i]) & GEN_MASK), 1'b0});
        end
    end

    always_comb
    begin
        logic                   found;
        logic [WAY_W-1:0]       sel;
        logic [WAY_W-1:0]       best;
        logic signed [RV_W-1:0] bestv;
        logic [ENTRY_W-1:0]     ent;

        found       = 1'b0;
        sel         = '0;
        best        = '0;
        bestv       = rv[0];
        ent         = '0;
        row_new     = row_rd;
        wr_en       = 1'b0;
        result_next = '0;

        if (item_reg.func == FUNC_WRITE)
        begin
            result_next.slot = item_reg.way;
            if ({1'b0, item_reg.way} < 3'(WAYS))
            begin
                for (int i = 0; i < WAYS; i++)
                begin
                    if (item_reg.way == WAY_W'(i))
                    begin
                        ent = row_rd[i*ENTRY_W +: ENTRY_W];
                        row_new[i*ENTRY_W +: ENTRY_W] =
                            {tag, gen8 | {6'd0, item_reg.bound}, item_reg.depth};
                    end
                end
                wr_en                   = 1'b1;
                result_next.entry_depth = ent[7:0];
                result_next.entry_bound = ent[9:8];
            end
        end
        else
        begin
            // First way that is empty or carries the probed tag.
            for (int i = 0; i < WAYS; i++)
            begin
                if (!found && (etag[i] == '0 || etag[i] == tag))
                begin
                    found = 1'b1;
                    sel   = WAY_W'(i);
                end
            end
            // Lowest replacement value; the earlier way wins a tie.
            for (int i = 1; i < WAYS; i++)
            begin
                if (bestv > rv[i])
                begin
                    bestv = rv[i];
                    best  = WAY_W'(i);
                end
            end
            if (!found)
            begin
                sel = best;
            end
            for (int i = 0; i < WAYS; i++)
            begin
                if (sel == WAY_W'(i))
                begin
                    ent = row_rd[i*ENTRY_W +: ENTRY_W];
                    if (found && etag[i] != '0 && (egb[i] & GEN_MASK) != gen8)
                    begin
                        row_new[i*ENTRY_W+8 +: 8] = egb[i] + GEN_STEP;
                        wr_en = 1'b1;
                    end
                end
            end
            result_next.hit         = found && (ent[31:16] != '0);
            result_next.slot        = sel;
            result_next.entry_depth = ent[7:0];
            result_next.entry_bound = ent[9:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gen_reg <= cfg_wdata;
            end
            done_reg <= cmd.exec;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/core/hash_cluster_probe_replace.sv
// ----------------------------------------------------------------------------
// hash_cluster_probe_replace
// Set-associative hash table of three-entry clusters with probe and write.
// ----------------------------------------------------------------------------
// The result strobe (done) is high in the cycle after the execute cycle.
// Busy stays high through the execute cycle, so a new item is taken only
// after the registered read of the last item's cluster row and its compare,
// select and write-back are through.
// Reset: after rst_n releases, a clearing pass writes every one of the 1024
// cluster rows, one per cycle, with busy high; the generation register is 0.
// The receiver cannot stall; done lasts exactly one cycle per item.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_cluster_probe_replace (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire hcpr_pkg::item_t               item,
    output logic                               done,
    output hcpr_pkg::result_t                  result,
    input  wire logic                          cfg_we,
    input  wire logic [hcpr_pkg::GEN_W-1:0]    cfg_wdata
);
    import hcpr_pkg::*;

    // The controller sequences clearing and the load and execute cycles of each
    // item; the datapath holds the table, the item and the generation register.
    cmd_t cmd;

    hcpr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    hcpr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hash cluster probe and replace block. A queue
// of pending items feeds a falling-edge driver. A rising-edge monitor keeps
// a shadow copy of the cluster table and the generation register, predicts
// every accepted item, and compares each strobed result with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import hcpr_pkg::*;

    // Bench sizing. The limit covers the clearing pass, every phase at its
    // worst idle rate and all drains, many times over.
    localparam int  RANDOM_PER_PHASE = 213;
    localparam int  NUM_PHASES       = 8;
    localparam int  NUM_HOT          = 6;
    localparam int  NUM_TAGS         = 5;
    localparam int  LATENCY          = 2;
    localparam int  DRAIN_LIMIT      = 200;
    localparam int  MAX_REPORTS      = 10;
    localparam real RUN_LIMIT_NS     = 1_000_000.0;

    // Generation and sender idle rate of each phase. A zero idle rate also
    // stands for the phase in which only the receiver would stall, since
    // the receiver cannot hold results off.
    localparam logic [GEN_W-1:0] PHASE_GEN [NUM_PHASES] =
        '{6'd0, 6'd63, 6'd1, 6'd62, 6'd0, 6'd32, 6'd0, 6'd63};
    localparam int PHASE_IDLE [NUM_PHASES] = '{0, 56, 0, 17, 56, 17, 0, 56};

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    item_t            item      = '0;
    logic             done;
    result_t          result;
    logic             cfg_we    = 1'b0;
    logic [GEN_W-1:0] cfg_wdata = '0;

    // Shadow state of the block.
    logic [ENTRY_W-1:0] shadow_table [CLUSTERS][WAYS];
    logic [GEN_W-1:0]   live_gen = '0;

    // Items waiting to be driven, and lookups waiting for their result.
    item_t   item_backlog [$];
    result_t predicted_lookups [$];

    // A small set of clusters and tags that most random items aim at, so
    // that clusters fill up, tags match and victims have to be chosen.
    logic [CLUSTER_W-1:0] hot_cluster [NUM_HOT];
    logic [TAG_W-1:0]     hot_tag [NUM_TAGS];

    logic taken    = 1'b0;
    int   idle_pct = 0;
    int   errors   = 0;

    hash_cluster_probe_replace u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Every failure goes through here. Only the first few are described.
    task automatic count_failure(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("ERROR: %s", msg);
        end
    endtask

    // Predicts one item against the shadow table and applies its effect.
    // A write to an existing way stores the tag, depth and bound stamped with the current
    // generation. A probe takes the first empty or matching way, ages a
    // matching entry of another generation one step forward, and otherwise
    // names the way with the lowest depth minus twice its masked age.
    function automatic result_t lookup_and_update(input item_t it);
        result_t              res;
        logic [CLUSTER_W-1:0] cl;
        logic [TAG_W-1:0]     tag;
        logic [7:0]           gen8;
        logic [7:0]           age;
        logic [ENTRY_W-1:0]   e;
        int                   w;
        int                   best;
        int                   v;
        int                   vbest;
        bit                   found;

        cl    = CLUSTER_W'(it.key & 64'(CLUSTERS - 1));
        tag   = it.key[63:48];
        gen8  = {live_gen, 2'b00};
        res   = '0;
        found = 1'b0;
        best  = 0;
        vbest = 0;

        if (it.func == FUNC_WRITE)
        begin
            // A way past the last one stores nothing and reports no hit, zero depth and zero bound.
            res.slot = it.way;
            if (it.way < WAYS)
            begin
                e = shadow_table[cl][it.way];
                res.entry_depth = e[7:0];
                res.entry_bound = e[9:8];
                shadow_table[cl][it.way] = {tag, gen8 | {6'b0, it.bound}, it.depth};
            end
            return res;
        end

        for (w = 0; w < WAYS; w++)
        begin
            e = shadow_table[cl][w];
            if (!found && (e[31:16] == '0 || e[31:16] == tag))
            begin
                found           = 1'b1;
                res.hit         = (e[31:16] != '0);
                res.slot        = WAY_W'(w);
                res.entry_depth = e[7:0];
                res.entry_bound = e[9:8];
                if (res.hit && (e[15:8] & GEN_MASK) != gen8)
                begin
                    shadow_table[cl][w][15:8] = e[15:8] + GEN_STEP;
                end
            end
        end

        if (!found)
        begin
            for (w = 0; w < WAYS; w++)
            begin
                e   = shadow_table[cl][w];
                age = (AGE_BIAS + gen8 - e[15:8]) & GEN_MASK;
                v   = int'($signed(e[7:0])) - 2 * int'(age);
                if (w == 0 || v < vbest)
                begin
                    vbest = v;
                    best  = w;
                end
            end
            e               = shadow_table[cl][best];
            res.slot        = WAY_W'(best);
            res.entry_depth = e[7:0];
            res.entry_bound = e[9:8];
        end
        return res;
    endfunction

    // A key with the given tag and cluster and random bits in between.
    function automatic logic [63:0] cluster_key(input logic [TAG_W-1:0] tag,
                                                input logic [CLUSTER_W-1:0] cl);
        logic [63:0] k;

        k                = {$urandom, $urandom};
        k[63:48]         = tag;
        k[CLUSTER_W-1:0] = cl;
        return k;
    endfunction

    function automatic item_t make_item(input logic f, input logic [63:0] k,
                                        input logic [WAY_W-1:0] w,
                                        input logic signed [7:0] d,
                                        input logic [1:0] b);
        item_t it;

        it.func  = f;
        it.key   = k;
        it.way   = w;
        it.depth = d;
        it.bound = b;
        return it;
    endfunction

    // Most random items hit the hot clusters with tags from the small pool,
    // a few carry a zero tag, and the rest are fully random noise.
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;

        pick     = $urandom_range(99);
        it.func  = ($urandom_range(99) < 40) ? FUNC_WRITE : FUNC_PROBE;
        it.key   = {$urandom, $urandom};
        it.way   = ($urandom_range(15) == 0) ? 2'd3 : WAY_W'($urandom_range(WAYS - 1));
        it.depth = 8'($urandom);
        it.bound = 2'($urandom);
        if (pick < 88)
        begin
            it.key = cluster_key((pick < 5) ? TAG_W'(0) : hot_tag[$urandom_range(NUM_TAGS - 1)],
                                 hot_cluster[$urandom_range(NUM_HOT - 1)]);
        end
        return it;
    endfunction

    // Waits until every item has been driven and every result has come,
    // then lets the pipeline settle before anything else is touched.
    task automatic drain_lookups();
        int waited;

        waited = 0;
        while (item_backlog.size() != 0 || start)
        begin
            @(negedge clk);
        end
        while (predicted_lookups.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (predicted_lookups.size() != 0)
        begin
            count_failure($sformatf("%0d results never came", predicted_lookups.size()));
            errors += predicted_lookups.size() - 1;
            predicted_lookups.delete();
        end
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    // The generation register is only written while nothing is in flight.
    task automatic set_generation(input logic [GEN_W-1:0] g);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Driver: an item stays on the port until the block takes it. Once it
    // has been taken, or when nothing is offered, the next item goes out
    // unless this cycle is chosen to be idle.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || taken)
        begin
            if (item_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                item  <= item_backlog.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: results are checked before the item taken at the same edge
    // is predicted, so an empty queue is never filled by the wrong item.
    always @(posedge clk)
    begin
        taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                live_gen <= cfg_wdata;
            end
            if (done)
            begin
                if (predicted_lookups.size() == 0)
                begin
                    count_failure("result strobed with no item outstanding");
                end
                else if (result.hit         !== predicted_lookups[0].hit  ||
                         result.slot        !== predicted_lookups[0].slot ||
                         result.entry_depth !== predicted_lookups[0].entry_depth ||
                         result.entry_bound !== predicted_lookups[0].entry_bound)
                begin
                    count_failure($sformatf(
                        "expected hit=%0b slot=%0d depth=%0d bound=%0d, got hit=%0b slot=%0d depth=%0d bound=%0d",
                        predicted_lookups[0].hit, predicted_lookups[0].slot,
                        predicted_lookups[0].entry_depth, predicted_lookups[0].entry_bound,
                        result.hit, result.slot, result.entry_depth, result.entry_bound));
                end
                if (predicted_lookups.size() != 0)
                begin
                    void'(predicted_lookups.pop_front());
                end
            end
            if (start && !busy)
            begin
                predicted_lookups.push_back(lookup_and_update(item));
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin : stimulus
        // Tags for the directed part of the test.
        logic [TAG_W-1:0]     tag_a;
        logic [TAG_W-1:0]     tag_b;
        logic [TAG_W-1:0]     tag_c;
        logic [TAG_W-1:0]     tag_d;
        logic [CLUSTER_W-1:0] dc;
        int                   p;
        int                   n;
        int                   c;
        int                   w;

        tag_a = 16'hFFFF;
        tag_b = 16'h0001;
        tag_c = 16'h8000;
        tag_d = 16'h1234;
        dc    = CLUSTER_W'(5);

        // The block clears its table after reset; the shadow starts empty.
        for (c = 0; c < CLUSTERS; c++)
        begin
            for (w = 0; w < WAYS; w++)
            begin
                shadow_table[c][w] = '0;
            end
        end

        // Hot clusters include the first and last one; hot tags are nonzero.
        hot_cluster[0] = '0;
        hot_cluster[1] = CLUSTER_W'(CLUSTERS - 1);
        for (n = 2; n < NUM_HOT; n++)
        begin
            hot_cluster[n] = CLUSTER_W'($urandom_range(CLUSTERS - 1));
        end
        for (n = 0; n < NUM_TAGS; n++)
        begin
            hot_tag[n] = TAG_W'($urandom_range(16'hFFFF, 1));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Let the clearing pass finish before the first register write.
        repeat (2) @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct = PHASE_IDLE[p];
            set_generation((p == 4) ? GEN_W'($urandom) : PHASE_GEN[p]);

            if (p == 0)
            begin
                // An empty cluster: the first way is free.
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key(tag_a, dc), 0, 0, 0));
                // Fill the cluster with the extremes of depth and bound.
                item_backlog.push_back(make_item(FUNC_WRITE, cluster_key(tag_a, dc), 0, 127, 3));
                item_backlog.push_back(make_item(FUNC_WRITE, cluster_key(tag_b, dc), 1, -128, 0));
                item_backlog.push_back(make_item(FUNC_WRITE, cluster_key(tag_c, dc), 2, 0, 1));
                // A write past the last way stores nothing.
                item_backlog.push_back(make_item(FUNC_WRITE, cluster_key(tag_d, dc), 3, 55, 2));
                // Hits on every way, then a miss that must pick a victim.
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key(tag_a, dc), 2, -1, 3));
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key(tag_b, dc), 1, 1, 0));
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key(tag_c, dc), 0, 0, 2));
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key(tag_d, dc), 3, 7, 1));
                // A zero tag on a full cluster matches nothing.
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key('0, dc), 0, 0, 0));
                // Writing a zero tag empties a way; probes then land there.
                item_backlog.push_back(make_item(FUNC_WRITE, cluster_key('0, dc), 1, 9, 2));
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key(tag_d, dc), 0, 0, 0));
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key('0, dc), 0, 0, 0));
                // All-ones and all-zero keys hit the last and first cluster.
                item_backlog.push_back(make_item(FUNC_WRITE, '1, 2, -1, 3));
                item_backlog.push_back(make_item(FUNC_PROBE, '1, 3, 127, 3));
                item_backlog.push_back(make_item(FUNC_PROBE, '0, 0, 0, 0));
                item_backlog.push_back(make_item(FUNC_WRITE, '0, 0, -128, 3));
            end
            else if (p == 1)
            begin
                // With a new generation, matching entries age one step per
                // probe, and a miss weighs depth against age.
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key(tag_a, dc), 0, 0, 0));
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key(tag_a, dc), 0, 0, 0));
                item_backlog.push_back(make_item(FUNC_WRITE, cluster_key(16'h00E0, dc), 1, -100, 1));
                item_backlog.push_back(make_item(FUNC_PROBE, cluster_key(16'h00F0, dc), 0, 0, 0));
            end

            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                item_backlog.push_back(random_item());
            end

            // The sender holds off here until every result has come.
            drain_lookups();
        end

        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### hash_cluster_probe_replace.f
rtl/core/hcpr_pkg.sv
rtl/core/hcpr_ram.sv
rtl/core/hcpr_ctrl.sv
rtl/core/hcpr_dp.sv
rtl/core/hash_cluster_probe_replace.sv
verif/tb_top.sv
